### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define DBPQ_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define DBPQ_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dbpq_pkg.sv
`timescale 1ns / 1ps

package dbpq_pkg;

    localparam logic [1:0] Q_NONE  = 2'd0;
    localparam logic [1:0] Q_SPLIT = 2'd1;
    localparam logic [1:0] Q_MERGE = 2'd2;
    localparam logic [1:0] Q_ALIAS = 2'd3;

    localparam int ID_W   = 12;
    localparam int EXT_W  = 13;
    localparam int CHG_W  = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 56;

    typedef struct packed {
        logic clear;
        logic accept;
        logic look;
        logic unlink;
        logic scan_rd;
        logic scan_chk;
        logic push_rd;
        logic push_wr;
        logic heads_rd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic valid_in;
        logic same;
        logic was_nz;
        logic new_nz;
        logic need_scan;
        logic scan_end;
        logic scan_hit;
        logic out_room;
    } stat_t;

endpackage

### rtl/dbpq_ram.sv
`timescale 1ns / 1ps

module dbpq_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dbpq_ctrl.sv
`timescale 1ns / 1ps

module dbpq_ctrl
    import dbpq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  stat_t st,
    output cmd_t  cmd,
    output logic  ready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_UNLINK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PUSH_RD,
        S_PUSH_WR,
        S_HEADS_RD,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.valid_in ? S_LOOK : S_HEADS_RD;
                end
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (st.same)
                begin
                    state_next = S_HEADS_RD;
                end
                else
                begin
                    state_next = st.was_nz ? S_UNLINK : S_PUSH_RD;
                end
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = st.need_scan ? S_SCAN_RD : S_PUSH_RD;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = st.scan_end ? S_PUSH_RD : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = st.scan_hit ? S_PUSH_RD : S_SCAN_RD;
            end
            S_PUSH_RD:
            begin
                cmd.push_rd = 1'b1;
                state_next  = st.new_nz ? S_PUSH_WR : S_HEADS_RD;
            end
            S_PUSH_WR:
            begin
                cmd.push_wr = 1'b1;
                state_next  = S_HEADS_RD;
            end
            S_HEADS_RD:
            begin
                cmd.heads_rd = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_room)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign ready = ready_reg;

endmodule

### rtl/dbpq_datapath.sv
`timescale 1ns / 1ps

module dbpq_datapath
    import dbpq_pkg::*;
#(
    parameter int NODES   = 4096,
    parameter int BUCKETS = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            st,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    `include "assert_macros.svh"

    localparam int NW      = $clog2(NODES);
    localparam int BW      = $clog2(BUCKETS);
    localparam int PW      = $clog2(NODES + 1);
    localparam int TW      = BW + 2;
    localparam int CLR_LEN = (NODES > BUCKETS) ? NODES : BUCKETS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam logic [PW-1:0]        NULLP = PW'(NODES);
    localparam logic signed [TW-1:0] BK    = TW'(BUCKETS);

    logic [ID_W-1:0] in_node, in_bucket;
    logic [1:0]      in_q;

    logic [NW-1:0]          n_reg;
    logic [1:0]             q_reg;
    logic [BW-1:0]          b_reg;
    logic signed [CHG_W-1:0] chg_reg;
    logic signed [TW-1:0]   split_top_reg, merge_bot_reg, scan_reg;
    logic                   topv_reg, botv_reg;
    logic [CW-1:0]          clr_reg;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    logic [1:0]    nq_rd;
    logic [BW-1:0] nb_rd;
    logic [PW-1:0] np_rd, nn_rd, sh_rd, mh_rd, scan_head, push_head;
    logic          was_split, new_split;
    logic signed [TW-1:0] obx, bx;

    logic          nq_we, nb_we, np_we, nn_we, sh_we, mh_we;
    logic [NW-1:0] nq_wa, nb_wa, np_wa, nn_wa;
    logic [1:0]    nq_wd;
    logic [BW-1:0] nb_wd, sh_wa, mh_wa, sh_ra, mh_ra;
    logic [PW-1:0] np_wd, nn_wd, sh_wd, mh_wd;
    logic          sh_re, mh_re;

    assign in_node   = s_tdata[ID_W-1:0];
    assign in_bucket = s_tdata[2*ID_W-1:ID_W];
    assign in_q      = (s_tuser == Q_ALIAS) ? Q_SPLIT : s_tuser;

    assign was_split = (nq_rd == Q_SPLIT);
    assign new_split = (q_reg == Q_SPLIT);
    assign scan_head = was_split ? sh_rd : mh_rd;
    assign push_head = new_split ? sh_rd : mh_rd;
    assign obx       = $signed(TW'(nb_rd));
    assign bx        = $signed(TW'(b_reg));

    always_comb
    begin
        st.clear_last = (32'(clr_reg) == CLR_LEN - 1);
        st.valid_in   = (32'(in_node) < NODES) && (32'(in_bucket) < BUCKETS);
        st.same       = (nq_rd == q_reg) && (nb_rd == b_reg);
        st.was_nz     = (nq_rd != Q_NONE);
        st.new_nz     = (q_reg != Q_NONE);
        st.need_scan  = (np_rd == NULLP) && (nn_rd == NULLP) &&
                        (was_split ? (obx == split_top_reg) : (obx == merge_bot_reg));
        st.scan_end   = was_split ? (scan_reg < 0) : (scan_reg >= BK);
        st.scan_hit   = (scan_head != NULLP);
        st.out_room   = !m_tvalid_reg || m_tready;
    end

    always_comb
    begin
        nq_we = 1'b0; nq_wa = n_reg; nq_wd = q_reg;
        nb_we = 1'b0; nb_wa = n_reg; nb_wd = b_reg;
        np_we = 1'b0; np_wa = n_reg; np_wd = NULLP;
        nn_we = 1'b0; nn_wa = n_reg; nn_wd = NULLP;
        sh_we = 1'b0; sh_wa = b_reg; sh_wd = PW'(n_reg);
        mh_we = 1'b0; mh_wa = b_reg; mh_wd = PW'(n_reg);
        sh_re = 1'b0; sh_ra = b_reg;
        mh_re = 1'b0; mh_ra = b_reg;
        if (cmd.clear)
        begin
            nq_we = (32'(clr_reg) < NODES);   nq_wa = NW'(clr_reg); nq_wd = Q_NONE;
            nb_we = nq_we;                    nb_wa = NW'(clr_reg); nb_wd = '0;
            np_we = nq_we;                    np_wa = NW'(clr_reg);
            nn_we = nq_we;                    nn_wa = NW'(clr_reg);
            sh_we = (32'(clr_reg) < BUCKETS); sh_wa = BW'(clr_reg); sh_wd = NULLP;
            mh_we = sh_we;                    mh_wa = BW'(clr_reg); mh_wd = NULLP;
        end
        if (cmd.unlink)
        begin
            if (np_rd != NULLP)
            begin
                nn_we = 1'b1; nn_wa = NW'(np_rd); nn_wd = nn_rd;
            end
            else
            begin
                sh_we = was_split;  sh_wa = nb_rd; sh_wd = nn_rd;
                mh_we = !was_split; mh_wa = nb_rd; mh_wd = nn_rd;
            end
            if (nn_rd != NULLP)
            begin
                np_we = 1'b1; np_wa = NW'(nn_rd); np_wd = np_rd;
            end
        end
        if (cmd.scan_rd)
        begin
            sh_re = was_split && !st.scan_end;  sh_ra = BW'(scan_reg);
            mh_re = !was_split && !st.scan_end; mh_ra = BW'(scan_reg);
        end
        if (cmd.push_rd)
        begin
            nq_we = 1'b1;
            nb_we = 1'b1;
            np_we = 1'b1;
            nn_we = !st.new_nz;
            sh_re = new_split;
            mh_re = (q_reg == Q_MERGE);
        end
        if (cmd.push_wr)
        begin
            nn_we = 1'b1; nn_wd = push_head;
            sh_we = new_split;
            mh_we = !new_split;
            if (push_head != NULLP)
            begin
                np_we = 1'b1; np_wa = NW'(push_head); np_wd = PW'(n_reg);
            end
        end
        if (cmd.heads_rd)
        begin
            sh_re = (split_top_reg >= 0);  sh_ra = BW'(split_top_reg);
            mh_re = (merge_bot_reg < BK);  mh_ra = BW'(merge_bot_reg);
        end
    end

    dbpq_ram #(.WIDTH(2), .DEPTH(NODES)) u_node_queue (
        .clk(clk), .we(nq_we), .waddr(nq_wa), .wdata(nq_wd),
        .re(cmd.accept), .raddr(NW'(in_node)), .rdata(nq_rd)
    );
    dbpq_ram #(.WIDTH(BW), .DEPTH(NODES)) u_node_bucket (
        .clk(clk), .we(nb_we), .waddr(nb_wa), .wdata(nb_wd),
        .re(cmd.accept), .raddr(NW'(in_node)), .rdata(nb_rd)
    );
    dbpq_ram #(.WIDTH(PW), .DEPTH(NODES)) u_node_prev (
        .clk(clk), .we(np_we), .waddr(np_wa), .wdata(np_wd),
        .re(cmd.accept), .raddr(NW'(in_node)), .rdata(np_rd)
    );
    dbpq_ram #(.WIDTH(PW), .DEPTH(NODES)) u_node_next (
        .clk(clk), .we(nn_we), .waddr(nn_wa), .wdata(nn_wd),
        .re(cmd.accept), .raddr(NW'(in_node)), .rdata(nn_rd)
    );
    dbpq_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_split_heads (
        .clk(clk), .we(sh_we), .waddr(sh_wa), .wdata(sh_wd),
        .re(sh_re), .raddr(sh_ra), .rdata(sh_rd)
    );
    dbpq_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_merge_heads (
        .clk(clk), .we(mh_we), .waddr(mh_wa), .wdata(mh_wd),
        .re(mh_re), .raddr(mh_ra), .rdata(mh_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            split_top_reg <= -TW'(1);
            merge_bot_reg <= BK;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.scan_rd && st.scan_end)
            begin
                if (was_split)
                begin
                    split_top_reg <= scan_reg;
                end
                else
                begin
                    merge_bot_reg <= scan_reg;
                end
            end
            if (cmd.scan_chk && st.scan_hit)
            begin
                if (was_split)
                begin
                    split_top_reg <= scan_reg;
                end
                else
                begin
                    merge_bot_reg <= scan_reg;
                end
            end
            if (cmd.push_wr && push_head == NULLP)
            begin
                if (new_split && bx > split_top_reg)
                begin
                    split_top_reg <= bx;
                end
                if (!new_split && bx < merge_bot_reg)
                begin
                    merge_bot_reg <= bx;
                end
            end
            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            n_reg   <= NW'(in_node);
            q_reg   <= in_q;
            b_reg   <= BW'(in_bucket);
            chg_reg <= '0;
        end
        if (cmd.look && !st.same)
        begin
            if (st.was_nz && !st.new_nz)
            begin
                chg_reg <= -CHG_W'(1);
            end
            else if (!st.was_nz && st.new_nz)
            begin
                chg_reg <= CHG_W'(1);
            end
        end
        if (cmd.unlink)
        begin
            scan_reg <= was_split ? obx - TW'(1) : obx + TW'(1);
        end
        if (cmd.scan_chk && !st.scan_hit)
        begin
            scan_reg <= was_split ? scan_reg - TW'(1) : scan_reg + TW'(1);
        end
        if (cmd.heads_rd)
        begin
            topv_reg <= (split_top_reg >= 0);
            botv_reg <= (merge_bot_reg < BK);
        end
        if (cmd.emit)
        begin
            m_tdata_reg <= {2'b00, chg_reg,
                            botv_reg && (mh_rd != NULLP),
                            (botv_reg && mh_rd != NULLP) ? ID_W'(mh_rd) : ID_W'(0),
                            topv_reg && (sh_rd != NULLP),
                            (topv_reg && sh_rd != NULLP) ? ID_W'(sh_rd) : ID_W'(0),
                            EXT_W'(merge_bot_reg), EXT_W'(split_top_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DBPQ_CHECK(a_split_range, split_top_reg >= -1 && split_top_reg < BK,
        "split extreme out of range")
    `DBPQ_CHECK(a_merge_range, merge_bot_reg >= 0 && merge_bot_reg <= BK,
        "merge extreme out of range")
    `DBPQ_NEXT(a_emit_room, cmd.emit && m_tvalid_reg && !m_tready, 1'b0,
        "result loaded over a waiting beat")

endmodule

### rtl/dual_bucket_priority_queue_core.sv
`timescale 1ns / 1ps
// Channel   Group                      Beat contents
// input     s_tvalid s_tready s_tdata   node_id, bucket; s_tuser target_queue
// output    m_tvalid m_tready m_tdata   extremes, head nodes, membership change
//
// A move that empties an extreme bucket rescans the buckets beyond it in turn,
// until one holds a node or the scan runs off the end.
// After reset the tables are swept, one entry a cycle, with s_tready low.
// A finished beat waits in the output register; the next move is accepted meanwhile.

module dual_bucket_priority_queue_core
    import dbpq_pkg::*;
#(
    parameter int NODES   = 4096,
    parameter int BUCKETS = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // node_id[11:0], bucket[23:12]
    input  logic [1:0]       s_tuser,   // target_queue[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // split_max[12:0], merge_min[25:13],
                                        // split_top_node[37:26], split_top_valid[38],
                                        // merge_bottom_node[50:39],
                                        // merge_bottom_valid[51], membership_change[53:52]
);

    cmd_t  cmd;
    stat_t st;

    dbpq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid),
        .st(st), .cmd(cmd), .ready(s_tready)
    );

    dbpq_datapath #(.NODES(NODES), .BUCKETS(BUCKETS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

### bench/dual_bucket_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module dual_bucket_priority_queue_core_tb;
    import dbpq_pkg::*;

    localparam int NODES    = 4096;
    localparam int BUCKETS  = 4096;
    localparam int NIL      = NODES;
    localparam int WDOG_MAX = 60000;

    typedef struct {
        logic signed [12:0] split_max;
        logic [12:0]        merge_min;
        logic [11:0]        split_top_node;
        logic               split_top_valid;
        logic [11:0]        merge_bottom_node;
        logic               merge_bottom_valid;
        logic signed [1:0]  membership_change;
    } bucket_view_t;

    class move_scoreboard;
        logic [1:0]   node_q[NODES];
        logic [11:0]  node_bkt[NODES];
        int           prev_of[NODES];
        int           next_of[NODES];
        int           split_head[BUCKETS];
        int           merge_head[BUCKETS];
        int           split_top;
        int           merge_bot;
        bucket_view_t pending[$];
        int           errors;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                node_q[i] = Q_NONE;
                node_bkt[i] = '0;
                prev_of[i] = NIL;
                next_of[i] = NIL;
            end
            for (int i = 0; i < BUCKETS; i++)
            begin
                split_head[i] = NIL;
                merge_head[i] = NIL;
            end
            split_top = -1;
            merge_bot = BUCKETS;
            errors = 0;
        endfunction

        function void detach(int n);
            logic [1:0] q;
            int b;
            int p;
            int nx;
            int i;
            q = node_q[n];
            b = node_bkt[n];
            p = prev_of[n];
            nx = next_of[n];
            if (p != NIL)
                next_of[p] = nx;
            else
            begin
                if (q == Q_SPLIT)
                    split_head[b] = nx;
                else
                    merge_head[b] = nx;
                if (nx == NIL)
                begin
                    if (q == Q_SPLIT && b == split_top)
                    begin
                        i = b;
                        while (i >= 0 && split_head[i] == NIL)
                            i--;
                        split_top = i;
                    end
                    else if (q != Q_SPLIT && b == merge_bot)
                    begin
                        i = b;
                        while (i < BUCKETS && merge_head[i] == NIL)
                            i++;
                        merge_bot = i;
                    end
                end
            end
            if (nx != NIL)
                prev_of[nx] = p;
            prev_of[n] = NIL;
            next_of[n] = NIL;
            node_q[n] = Q_NONE;
        endfunction

        function void attach(int n, logic [1:0] q, int b);
            int old;
            old = (q == Q_SPLIT) ? split_head[b] : merge_head[b];
            prev_of[n] = NIL;
            next_of[n] = old;
            if (q == Q_SPLIT)
                split_head[b] = n;
            else
                merge_head[b] = n;
            if (old != NIL)
                prev_of[old] = n;
            else if (q == Q_SPLIT)
            begin
                if (b > split_top)
                    split_top = b;
            end
            else if (b < merge_bot)
                merge_bot = b;
            node_q[n] = q;
        endfunction

        function void note_move(logic [11:0] n, logic [1:0] tq, logic [11:0] b);
            bucket_view_t r;
            logic [1:0] q;
            logic [1:0] was;
            q = (tq == Q_ALIAS) ? Q_SPLIT : tq;
            r.membership_change = 2'sd0;
            if (!(node_q[n] == q && node_bkt[n] == b))
            begin
                was = node_q[n];
                if (was != Q_NONE && q == Q_NONE)
                    r.membership_change = -2'sd1;
                else if (was == Q_NONE && q != Q_NONE)
                    r.membership_change = 2'sd1;
                if (was != Q_NONE)
                    detach(n);
                node_bkt[n] = b;
                if (q != Q_NONE)
                    attach(n, q, b);
            end
            r.split_max = 13'(split_top);
            r.merge_min = 13'(merge_bot);
            r.split_top_valid = (split_top >= 0) && (split_head[split_top] != NIL);
            r.split_top_node = r.split_top_valid ? 12'(split_head[split_top]) : 12'd0;
            r.merge_bottom_valid = (merge_bot < BUCKETS) && (merge_head[merge_bot] != NIL);
            r.merge_bottom_node = r.merge_bottom_valid ? 12'(merge_head[merge_bot]) : 12'd0;
            pending.push_back(r);
        endfunction

        function void check_beat(logic [OUT_W-1:0] d);
            bucket_view_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected output beat %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[12:0] !== e.split_max)
            begin
                $error("split_max exp %0d got %0d", e.split_max, $signed(d[12:0]));
                errors++;
            end
            if (d[25:13] !== e.merge_min)
            begin
                $error("merge_min exp %0d got %0d", e.merge_min, d[25:13]);
                errors++;
            end
            if (d[37:26] !== e.split_top_node)
            begin
                $error("split_top_node exp %0d got %0d", e.split_top_node, d[37:26]);
                errors++;
            end
            if (d[38] !== e.split_top_valid)
            begin
                $error("split_top_valid exp %0d got %0d", e.split_top_valid, d[38]);
                errors++;
            end
            if (d[50:39] !== e.merge_bottom_node)
            begin
                $error("merge_bottom_node exp %0d got %0d", e.merge_bottom_node, d[50:39]);
                errors++;
            end
            if (d[51] !== e.merge_bottom_valid)
            begin
                $error("merge_bottom_valid exp %0d got %0d", e.merge_bottom_valid, d[51]);
                errors++;
            end
            if (d[53:52] !== e.membership_change)
            begin
                $error("membership_change exp %0d got %0d", e.membership_change,
                       $signed(d[53:52]));
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    move_scoreboard sb;
    int             snd_idle;
    int             rcv_idle;
    int             quiet_cycles;

    dual_bucket_priority_queue_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
        m_tready <= rst_n && ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("dual_bucket_priority_queue_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_move(logic [11:0] n, logic [1:0] q, logic [11:0] b);
        if ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, n};
        s_tuser <= q;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_move(n, q, b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_moves(int count);
        logic [11:0] n;
        logic [11:0] b;
        logic [1:0]  q;
        int          pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            n = (pick < 95) ? 12'($urandom_range(47)) : 12'($urandom_range(4095));
            pick = $urandom_range(99);
            if (pick < 94)
                b = 12'($urandom_range(15));
            else if (pick < 97)
                b = 12'(4095 - $urandom_range(15));
            else
                b = 12'($urandom_range(4095));
            pick = $urandom_range(99);
            q = (pick < 15) ? Q_NONE : (pick < 55) ? Q_SPLIT : (pick < 92) ? Q_MERGE : Q_ALIAS;
            send_move(n, q, b);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = Q_NONE;
        m_tready = 1'b0;
        quiet_cycles = 0;
        snd_idle = 19;
        rcv_idle = 88;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_move(12'd0, Q_SPLIT, 12'd0);
        send_move(12'd4095, Q_SPLIT, 12'd4095);
        send_move(12'd4095, Q_SPLIT, 12'd4095);
        send_move(12'd7, Q_ALIAS, 12'd4095);
        send_move(12'd7, Q_MERGE, 12'd4095);
        send_move(12'd8, Q_MERGE, 12'd0);
        send_move(12'd9, Q_MERGE, 12'd0);
        send_move(12'd4095, Q_NONE, 12'd100);
        send_move(12'd4095, Q_NONE, 12'd100);
        send_move(12'd5, Q_NONE, 12'd4095);
        send_move(12'd8, Q_NONE, 12'd0);
        send_move(12'd9, Q_SPLIT, 12'd2048);
        send_move(12'd0, Q_MERGE, 12'd1);
        send_move(12'd0, Q_NONE, 12'd0);
        send_move(12'd7, Q_NONE, 12'd0);
        send_move(12'd9, Q_NONE, 12'd0);
        send_move(12'd2730, Q_ALIAS, 12'd1365);
        send_move(12'd1365, Q_MERGE, 12'd2730);
        send_move(12'd2730, Q_MERGE, 12'd2730);
        send_move(12'd1365, Q_NONE, 12'd0);
        send_move(12'd2730, Q_NONE, 12'd0);

        random_moves(340);
        drain();
        snd_idle = 88;
        rcv_idle = 19;
        random_moves(340);
        drain();
        snd_idle = 0;
        rcv_idle = 0;
        random_moves(350);
        drain();
        repeat (40) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dual_bucket_priority_queue_core_tb: done, clean");
        else
            $display("dual_bucket_priority_queue_core_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/dbpq_pkg.sv
rtl/dbpq_ram.sv
rtl/dbpq_ctrl.sv
rtl/dbpq_datapath.sv
rtl/dual_bucket_priority_queue_core.sv
bench/dual_bucket_priority_queue_core_tb.sv
